// ===== hdl/sljfr_pkg.sv =====
// Package for the sync/length/XOR frame receiver.
// Holds sizes, the parser state type and the result record; no dependencies.
package sljfr_pkg;

  localparam int MaxFrameLen = 10;
  localparam int StoreDepth  = MaxFrameLen - 1;
  localparam int AddrW       = $clog2(StoreDepth);
  localparam int LenW        = 4;
  localparam int ByteW       = 8;

  localparam logic [ByteW-1:0] SyncReset   = 8'h16;
  localparam logic [LenW-1:0]  MaxLenReset = 4'd10;
  localparam logic [LenW-1:0]  LenCap      = LenW'(MaxFrameLen);

  // Configuration register indexes.
  localparam logic CfgSyncByte = 1'b0;
  localparam logic CfgMaxLen   = 1'b1;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_LEN,
    ST_BODY,
    ST_ONE,
    ST_RD,
    ST_SHOW
  } phase_t;

  typedef struct packed {
    logic             status;
    logic [ByteW-1:0] payload;
    logic [LenW-1:0]  index;
    logic [LenW-1:0]  count;
    logic             last;
  } result_t;

endpackage

// ===== hdl/sljfr_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; no package needed.
module sljfr_ram #(
  parameter int Width = 8,
  parameter int Depth = 9
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/sljfr_parse.sv =====
// Frame parser and replay sequencer: hunts sync, checks length and XOR,
// stores payload in sljfr_ram and replays it. Depends on sljfr_pkg, sljfr_ram.
module sljfr_parse (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sljfr_pkg::ByteW-1:0] sync_byte,
  input  logic [sljfr_pkg::LenW-1:0]  max_length,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [sljfr_pkg::ByteW-1:0] rx_byte,
  output logic                        res_valid,
  input  logic                        res_ready,
  output sljfr_pkg::result_t          res
);

  sljfr_pkg::phase_t state_r, state_nxt;
  logic [sljfr_pkg::LenW-1:0]  flen_r, flen_nxt;
  logic [sljfr_pkg::LenW-1:0]  taken_r, taken_nxt;
  logic [sljfr_pkg::ByteW-1:0] xor_r, xor_nxt;
  logic [sljfr_pkg::LenW-1:0]  idx_r, idx_nxt;
  logic                        err_r, err_nxt;

  logic [sljfr_pkg::LenW-1:0]  limit;
  logic [sljfr_pkg::LenW-1:0]  count;
  logic                        len_ok;
  logic                        take;
  logic                        is_cksum;
  logic                        ram_wr;
  logic                        ram_rd;
  logic [sljfr_pkg::ByteW-1:0] ram_q;
  logic                        last_idx;

  assign limit  = (max_length > sljfr_pkg::LenCap) ? sljfr_pkg::LenCap : max_length;
  assign len_ok = (rx_byte != '0) && (rx_byte <= {4'b0, limit});
  assign count  = flen_r - 1'b1;
  assign take   = in_valid && in_ready;
  assign is_cksum = (taken_r >= count);
  assign last_idx = ((idx_r + 1'b1) == count);

  sljfr_ram #(
    .Width(sljfr_pkg::ByteW),
    .Depth(sljfr_pkg::StoreDepth)
  ) u_store (
    .clk    (clk),
    .wr_en  (ram_wr),
    .wr_addr(taken_r[sljfr_pkg::AddrW-1:0]),
    .wr_data(rx_byte),
    .rd_en  (ram_rd),
    .rd_addr(idx_r[sljfr_pkg::AddrW-1:0]),
    .rd_data(ram_q)
  );

  // Next state and data path registers.
  always_comb begin
    state_nxt = state_r;
    flen_nxt  = flen_r;
    taken_nxt = taken_r;
    xor_nxt   = xor_r;
    idx_nxt   = idx_r;
    err_nxt   = err_r;
    unique case (state_r)
      sljfr_pkg::ST_HUNT: begin
        if (take && (rx_byte == sync_byte)) begin
          state_nxt = sljfr_pkg::ST_LEN;
        end
      end
      sljfr_pkg::ST_LEN: begin
        if (take) begin
          if (len_ok) begin
            flen_nxt  = rx_byte[sljfr_pkg::LenW-1:0];
            taken_nxt = '0;
            xor_nxt   = rx_byte;
            state_nxt = sljfr_pkg::ST_BODY;
          end else if (rx_byte != sync_byte) begin
            state_nxt = sljfr_pkg::ST_HUNT;
          end
        end
      end
      sljfr_pkg::ST_BODY: begin
        if (take) begin
          if (is_cksum) begin
            idx_nxt = '0;
            if ((xor_r ^ rx_byte) != '0) begin
              err_nxt   = 1'b1;
              state_nxt = sljfr_pkg::ST_ONE;
            end else if (count == '0) begin
              err_nxt   = 1'b0;
              state_nxt = sljfr_pkg::ST_ONE;
            end else begin
              state_nxt = sljfr_pkg::ST_RD;
            end
          end else begin
            taken_nxt = taken_r + 1'b1;
            xor_nxt   = xor_r ^ rx_byte;
          end
        end
      end
      sljfr_pkg::ST_ONE: begin
        if (res_ready) begin
          state_nxt = sljfr_pkg::ST_HUNT;
        end
      end
      sljfr_pkg::ST_RD: begin
        state_nxt = sljfr_pkg::ST_SHOW;
      end
      sljfr_pkg::ST_SHOW: begin
        if (res_ready) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = last_idx ? sljfr_pkg::ST_HUNT : sljfr_pkg::ST_RD;
        end
      end
      default: begin
        state_nxt = sljfr_pkg::ST_HUNT;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready    = 1'b0;
    ram_wr      = 1'b0;
    ram_rd      = 1'b0;
    res_valid   = 1'b0;
    res.status  = 1'b0;
    res.payload = '0;
    res.index   = '0;
    res.count   = count;
    res.last    = 1'b1;
    unique case (state_r)
      sljfr_pkg::ST_HUNT, sljfr_pkg::ST_LEN: begin
        in_ready = 1'b1;
      end
      sljfr_pkg::ST_BODY: begin
        in_ready = 1'b1;
        ram_wr   = in_valid && !is_cksum;
      end
      sljfr_pkg::ST_ONE: begin
        res_valid  = 1'b1;
        res.status = err_r;
      end
      sljfr_pkg::ST_RD: begin
        ram_rd = 1'b1;
      end
      sljfr_pkg::ST_SHOW: begin
        res_valid   = 1'b1;
        res.payload = ram_q;
        res.index   = idx_r;
        res.last    = last_idx;
      end
      default: begin
        in_ready = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sljfr_pkg::ST_HUNT;
      flen_r  <= '0;
      taken_r <= '0;
      xor_r   <= '0;
      idx_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      flen_r  <= flen_nxt;
      taken_r <= taken_nxt;
      xor_r   <= xor_nxt;
      idx_r   <= idx_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== hdl/sljfr_outreg.sv =====
// Output register stage between the parser and the result stream.
// Depends on sljfr_pkg.
module sljfr_outreg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_valid,
  output logic               res_ready,
  input  sljfr_pkg::result_t res,
  output logic               out_valid,
  input  logic               out_ready,
  output sljfr_pkg::result_t out_res
);

  logic               valid_r, valid_nxt;
  sljfr_pkg::result_t data_r;

  // The register takes a new request when empty or when its content leaves now.
  assign res_ready = !valid_r || out_ready;
  assign valid_nxt = res_ready ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = data_r;

endmodule

// ===== hdl/sync_length_xor_frame_receiver.sv =====
// Sync/length/XOR frame receiver. Input bytes are accepted while parsing.
// A bad frame or a one-byte frame gives a single result after the checksum byte.
// A good frame of N payload bytes replays them from the payload RAM, each result
// read, then shown; input waits until the last result is registered.
// Reset (synchronous, active low) returns the parser to sync hunt and the
// registers to sync 0x16, max length 10; the payload RAM is not cleared.
module sync_length_xor_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] payload_byte, [11:8] byte_index,
                                  // [15:12] payload_count
  output logic        out_tuser,  // [0] frame_status
  output logic        out_tlast   // last_of_frame
);

  logic [sljfr_pkg::ByteW-1:0] sync_r, sync_nxt;
  logic [sljfr_pkg::LenW-1:0]  maxlen_r, maxlen_nxt;

  logic               res_valid;
  logic               res_ready;
  sljfr_pkg::result_t res;
  sljfr_pkg::result_t out_res;

  always_comb begin
    sync_nxt   = sync_r;
    maxlen_nxt = maxlen_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        sljfr_pkg::CfgSyncByte: sync_nxt   = cfg_wdata;
        sljfr_pkg::CfgMaxLen:   maxlen_nxt = cfg_wdata[sljfr_pkg::LenW-1:0];
        default:                sync_nxt   = sync_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r   <= sljfr_pkg::SyncReset;
      maxlen_r <= sljfr_pkg::MaxLenReset;
    end else begin
      sync_r   <= sync_nxt;
      maxlen_r <= maxlen_nxt;
    end
  end

  sljfr_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .sync_byte (sync_r),
    .max_length(maxlen_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  sljfr_outreg u_outreg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (out_res)
  );

  assign out_tdata = {out_res.count, out_res.index, out_res.payload};
  assign out_tuser = out_res.status;
  assign out_tlast = out_res.last;

endmodule
